@@ sv/pidpm_pkg.sv @@
package pidpm_pkg;

    localparam int GAIN_W     = 25;
    localparam int LIM_W      = 17;
    localparam int TRAVEL_W   = 20;
    localparam int CODE_W     = 8;
    localparam int DRIVE_W    = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 25;
    localparam int ACC_W      = 64;
    localparam int MUL_B_W    = 25;
    localparam int DIV_D_W    = 14;
    localparam int DIV_N_W    = 37;

    localparam int TICK_RATE_DEF = 20;
    localparam int PWM_RES_DEF   = 1000;

    localparam logic [GAIN_W-1:0]   GAIN_P_RST  = 25'd83886;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST  = 25'd33554;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST  = 25'd0;
    localparam logic [LIM_W-1:0]    NORM_RST    = 17'd6554;
    localparam logic [LIM_W-1:0]    FAST_RST    = 17'd26214;
    localparam logic [TRAVEL_W-1:0] TRAV0_RST   = 20'd1536;
    localparam logic [TRAVEL_W-1:0] TRAV1_RST   = 20'd1536;
    localparam logic [TRAVEL_W-1:0] TRAV2_RST   = 20'd2048;

    localparam logic signed [15:0]       ISUM_MAX = 16'sd32000;
    localparam logic signed [ACC_W-1:0]  TERM_MAX = 64'sd1 <<< 60;
    localparam logic [CODE_W-1:0]        CODE_MAX = 8'd2;
    localparam logic signed [31:0]       STOP_BAND = 32'sd5;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_ERR, S_DIV, S_MRATE, S_MP, S_MI, S_MD, S_LIM, S_MPWM, S_OUT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 4'd0,
        REG_GAIN_I       = 4'd1,
        REG_GAIN_D       = 4'd2,
        REG_NORMAL_LIMIT = 4'd3,
        REG_FAST_LIMIT   = 4'd4,
        REG_TRAVEL_ZERO  = 4'd5,
        REG_TRAVEL_ONE   = 4'd6,
        REG_TRAVEL_TWO   = 4'd7
    } t_reg_idx;

    typedef enum logic [CODE_W-1:0] {
        CODE_ZERO = 8'd0,
        CODE_ONE  = 8'd1,
        CODE_TWO  = 8'd2
    } t_code;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] a;
        logic [MUL_B_W-1:0]      b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [DIV_N_W-1:0] mag;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_term(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > TERM_MAX) begin
            r = TERM_MAX;
        end else if (v < -TERM_MAX) begin
            r = -TERM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ sv/pidpm_mul.sv @@
module pidpm_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pidpm_pkg::t_mul_req               i_req,
    output logic                              o_done,
    output logic signed [pidpm_pkg::ACC_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(pidpm_pkg::MUL_B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(pidpm_pkg::MUL_B_W - 1);

    logic signed [pidpm_pkg::ACC_W-1:0] r_a;
    logic signed [pidpm_pkg::ACC_W-1:0] r_acc;
    logic [pidpm_pkg::MUL_B_W-1:0]      r_b;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_busy;
    logic                               r_done;

    // Shift-and-add, one multiplier bit per cycle from the least significant end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + (r_b[0] ? r_a : '0);
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ sv/pidpm_div.sv @@
module pidpm_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidpm_pkg::t_div_req                  i_req,
    input  logic [pidpm_pkg::DIV_D_W-1:0]        i_den,
    output logic                                 o_done,
    output logic signed [pidpm_pkg::DIV_N_W:0]   o_quot
);

    localparam int N = pidpm_pkg::DIV_N_W;
    localparam int D = pidpm_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

    logic [N-1:0]     r_num;
    logic [D-1:0]     r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [D:0]       w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_num[N-1]};
    assign w_fit   = (w_trial >= {1'b0, i_den});

    // Restoring division: the remainder stays below the divisor, the
    // quotient bits fill the numerator register from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.mag;
                r_neg  <= i_req.neg;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fit ? D'(w_trial - {1'b0, i_den}) : w_trial[D-1:0];
                r_num <= {r_num[N-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});

endmodule

@@ sv/pid_position_move_controller.sv @@
// One item is in work at a time, and the next transaction is taken the cycle after the
// result is loaded into the output register. On a running move the result comes from
// one 37-step serial divider and five 25-step serial multiplies; the tick that ends a
// move skips the last multiply, and an idle tick uses neither unit.
// Reset (synchronous, active low) restores register defaults, stops any move, clears
// the PID state and drops any result not yet taken.
module pid_position_move_controller #(
    parameter int TICK_RATE      = pidpm_pkg::TICK_RATE_DEF,
    parameter int PWM_RESOLUTION = pidpm_pkg::PWM_RES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_new_command,
    input  logic [pidpm_pkg::CODE_W-1:0]           i_position_code,
    input  logic signed [31:0]                     i_encoder_count,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pidpm_pkg::DRIVE_W-1:0]   o_drive,
    output logic                                   o_moving,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pidpm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pidpm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AW = pidpm_pkg::ACC_W;

    pidpm_pkg::t_state r_state, n_state;

    logic [pidpm_pkg::GAIN_W-1:0]   r_gain_p, r_gain_i, r_gain_d;
    logic [pidpm_pkg::LIM_W-1:0]    r_norm, r_fast_lim;
    logic [pidpm_pkg::TRAVEL_W-1:0] r_trav0, r_trav1, r_trav2;

    logic                          r_cmd;
    logic [pidpm_pkg::CODE_W-1:0]  r_code;
    logic signed [31:0]            r_enc;
    logic signed [31:0]            r_target, n_target;
    logic                          r_fast, n_fast;
    logic                          r_running, n_running;
    logic signed [15:0]            r_esum, n_esum;
    logic signed [31:0]            r_last, n_last;
    logic signed [31:0]            r_e, n_e;
    logic signed [15:0]            r_isum, n_isum;
    logic signed [31:0]            r_rate, n_rate;
    logic signed [AW-1:0]          r_sum, n_sum;
    logic signed [pidpm_pkg::DRIVE_W-1:0] r_drive, n_drive;
    logic                          r_mov, n_mov;
    logic                          r_ov;
    logic signed [pidpm_pkg::DRIVE_W-1:0] r_od;
    logic                          r_om;

    pidpm_pkg::t_mul_req r_mreq, n_mreq;
    pidpm_pkg::t_div_req r_dreq, n_dreq;
    logic                                  w_mdone, w_ddone;
    logic signed [AW-1:0]                  w_prod;
    logic signed [pidpm_pkg::DIV_N_W:0]    w_quot;

    logic w_in_acc, w_out_load;
    logic signed [32:0]    w_diff;
    logic signed [31:0]    w_e;
    logic signed [31:0]    w_abs_e;
    logic signed [38:0]    w_isum_raw;
    logic signed [AW-1:0]  w_lim, w_pdrv;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == pidpm_pkg::S_OUT) && (!r_ov || i_out_ready);

    pidpm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    pidpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .i_den   (pidpm_pkg::DIV_D_W'(TICK_RATE)),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pidpm_pkg::S_IDLE:  if (w_in_acc) n_state = pidpm_pkg::S_CMD;
            pidpm_pkg::S_CMD:   n_state = pidpm_pkg::S_ERR;
            pidpm_pkg::S_ERR:   n_state = r_running ? pidpm_pkg::S_DIV : pidpm_pkg::S_OUT;
            pidpm_pkg::S_DIV:   if (w_ddone) n_state = pidpm_pkg::S_MRATE;
            pidpm_pkg::S_MRATE: if (w_mdone) n_state = pidpm_pkg::S_MP;
            pidpm_pkg::S_MP:    if (w_mdone) n_state = pidpm_pkg::S_MI;
            pidpm_pkg::S_MI:    if (w_mdone) n_state = pidpm_pkg::S_MD;
            pidpm_pkg::S_MD:    if (w_mdone) n_state = pidpm_pkg::S_LIM;
            pidpm_pkg::S_LIM: begin
                n_state = (r_e > -pidpm_pkg::STOP_BAND && r_e < pidpm_pkg::STOP_BAND)
                          ? pidpm_pkg::S_OUT : pidpm_pkg::S_MPWM;
            end
            pidpm_pkg::S_MPWM:  if (w_mdone) n_state = pidpm_pkg::S_OUT;
            pidpm_pkg::S_OUT:   if (w_out_load) n_state = pidpm_pkg::S_IDLE;
            default:            n_state = pidpm_pkg::S_IDLE;
        endcase
    end

    assign w_diff  = {r_target[31], r_target} - {r_enc[31], r_enc};
    assign w_e     = pidpm_pkg::sat32(AW'(w_diff));
    assign w_abs_e = w_e[31] ? -w_e : w_e;
    assign w_isum_raw = 39'(w_quot) + 39'(r_esum);
    assign w_lim   = $signed(AW'({(r_fast ? r_fast_lim : r_norm), 13'b0}));
    assign w_pdrv  = w_prod[AW-1] ? ((w_prod + AW'(64'sd536870911)) >>> 29) : (w_prod >>> 29);

    // Datapath and outputs of each state.
    always_comb begin
        n_target  = r_target;
        n_fast    = r_fast;
        n_running = r_running;
        n_esum    = r_esum;
        n_last    = r_last;
        n_e       = r_e;
        n_isum    = r_isum;
        n_rate    = r_rate;
        n_sum     = r_sum;
        n_drive   = r_drive;
        n_mov     = r_mov;
        n_mreq    = r_mreq;
        n_dreq    = r_dreq;
        n_mreq.start = 1'b0;
        n_dreq.start = 1'b0;
        unique case (r_state)
            pidpm_pkg::S_CMD: begin
                if (r_cmd && r_code <= pidpm_pkg::CODE_MAX) begin
                    case (r_code)
                        pidpm_pkg::CODE_ZERO: n_target = -$signed(32'(r_trav0));
                        pidpm_pkg::CODE_ONE:  n_target = $signed(32'(r_trav1));
                        default:              n_target = $signed(32'(r_trav2));
                    endcase
                    n_fast    = (r_code == pidpm_pkg::CODE_TWO);
                    n_running = 1'b1;
                    n_esum    = '0;
                    n_last    = '0;
                end
            end
            pidpm_pkg::S_ERR: begin
                n_drive = '0;
                n_mov   = 1'b0;
                n_e     = w_e;
                n_dreq.start = r_running;
                n_dreq.neg   = w_e[31];
                n_dreq.mag   = {w_abs_e[31:0], 5'b0};
            end
            pidpm_pkg::S_DIV: begin
                if (w_ddone) begin
                    if (w_isum_raw > 39'(pidpm_pkg::ISUM_MAX)) begin
                        n_isum = pidpm_pkg::ISUM_MAX;
                    end else if (w_isum_raw < -39'(pidpm_pkg::ISUM_MAX)) begin
                        n_isum = -pidpm_pkg::ISUM_MAX;
                    end else begin
                        n_isum = w_isum_raw[15:0];
                    end
                    n_mreq.start = 1'b1;
                    n_mreq.a     = AW'($signed({r_e[31], r_e} - {r_last[31], r_last}));
                    n_mreq.b     = pidpm_pkg::MUL_B_W'(TICK_RATE);
                end
            end
            pidpm_pkg::S_MRATE: begin
                if (w_mdone) begin
                    n_rate = pidpm_pkg::sat32(w_prod);
                    n_mreq.start = 1'b1;
                    n_mreq.a     = AW'(r_e) <<< 5;
                    n_mreq.b     = r_gain_p;
                end
            end
            pidpm_pkg::S_MP: begin
                if (w_mdone) begin
                    n_sum = pidpm_pkg::clamp_term(w_prod);
                    n_mreq.start = 1'b1;
                    n_mreq.a     = AW'(r_isum);
                    n_mreq.b     = r_gain_i;
                end
            end
            pidpm_pkg::S_MI: begin
                if (w_mdone) begin
                    n_sum = r_sum + pidpm_pkg::clamp_term(w_prod);
                    n_mreq.start = 1'b1;
                    n_mreq.a     = AW'(r_rate) <<< 5;
                    n_mreq.b     = r_gain_d;
                end
            end
            pidpm_pkg::S_MD: begin
                if (w_mdone) begin
                    n_sum = r_sum + pidpm_pkg::clamp_term(w_prod);
                end
            end
            pidpm_pkg::S_LIM: begin
                if (r_e > -pidpm_pkg::STOP_BAND && r_e < pidpm_pkg::STOP_BAND) begin
                    n_running = 1'b0;
                    n_esum    = '0;
                    n_last    = '0;
                    n_drive   = '0;
                    n_mov     = 1'b0;
                end else begin
                    n_esum = r_isum;
                    n_last = r_e;
                    n_mov  = 1'b1;
                    n_mreq.start = 1'b1;
                    n_mreq.b     = pidpm_pkg::MUL_B_W'(PWM_RESOLUTION);
                    if (r_sum > w_lim) begin
                        n_mreq.a = w_lim;
                    end else if (r_sum < -w_lim) begin
                        n_mreq.a = -w_lim;
                    end else begin
                        n_mreq.a = r_sum;
                    end
                end
            end
            pidpm_pkg::S_MPWM: begin
                if (w_mdone) begin
                    if (w_pdrv > AW'(64'sd1023)) begin
                        n_drive = 11'sd1023;
                    end else if (w_pdrv < -AW'(64'sd1024)) begin
                        n_drive = -11'sd1024;
                    end else begin
                        n_drive = w_pdrv[pidpm_pkg::DRIVE_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pidpm_pkg::S_IDLE;
            r_target  <= '0;
            r_fast    <= 1'b0;
            r_running <= 1'b0;
            r_esum    <= '0;
            r_last    <= '0;
            r_ov      <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            r_gain_p  <= pidpm_pkg::GAIN_P_RST;
            r_gain_i  <= pidpm_pkg::GAIN_I_RST;
            r_gain_d  <= pidpm_pkg::GAIN_D_RST;
            r_norm    <= pidpm_pkg::NORM_RST;
            r_fast_lim <= pidpm_pkg::FAST_RST;
            r_trav0   <= pidpm_pkg::TRAV0_RST;
            r_trav1   <= pidpm_pkg::TRAV1_RST;
            r_trav2   <= pidpm_pkg::TRAV2_RST;
        end else begin
            r_state   <= n_state;
            r_target  <= n_target;
            r_fast    <= n_fast;
            r_running <= n_running;
            r_esum    <= n_esum;
            r_last    <= n_last;
            r_mreq    <= n_mreq;
            r_dreq    <= n_dreq;
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pidpm_pkg::REG_GAIN_P:       r_gain_p   <= i_cfg_data;
                    pidpm_pkg::REG_GAIN_I:       r_gain_i   <= i_cfg_data;
                    pidpm_pkg::REG_GAIN_D:       r_gain_d   <= i_cfg_data;
                    pidpm_pkg::REG_NORMAL_LIMIT: r_norm     <= i_cfg_data[pidpm_pkg::LIM_W-1:0];
                    pidpm_pkg::REG_FAST_LIMIT:   r_fast_lim <= i_cfg_data[pidpm_pkg::LIM_W-1:0];
                    pidpm_pkg::REG_TRAVEL_ZERO:  r_trav0 <= i_cfg_data[pidpm_pkg::TRAVEL_W-1:0];
                    pidpm_pkg::REG_TRAVEL_ONE:   r_trav1 <= i_cfg_data[pidpm_pkg::TRAVEL_W-1:0];
                    pidpm_pkg::REG_TRAVEL_TWO:   r_trav2 <= i_cfg_data[pidpm_pkg::TRAVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= i_new_command;
            r_code <= i_position_code;
            r_enc  <= i_encoder_count;
        end
        r_e     <= n_e;
        r_isum  <= n_isum;
        r_rate  <= n_rate;
        r_sum   <= n_sum;
        r_drive <= n_drive;
        r_mov   <= n_mov;
        if (w_out_load) begin
            r_od <= r_drive;
            r_om <= r_mov;
        end
    end

    assign o_in_ready  = (r_state == pidpm_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_drive     = r_od;
    assign o_moving    = r_om;
    assign o_cfg_ready = 1'b1;

endmodule

@@ sv/pidpm_checker.sv @@
module pidpm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [pidpm_pkg::DRIVE_W-1:0] o_drive,
    input logic                                 o_moving
);

    // A result that has not been taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // Only one item is in work: after a transaction the input side closes.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // No drive is shown once the move has ended or when idle.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_moving |-> o_drive == '0)
        else $error("non-zero drive without a move");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pid_position_move_controller pidpm_checker u_pidpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive     (o_drive),
    .o_moving    (o_moving)
);
